>>> hdl/hssc_pkg.sv
// ----------------------------------------------------------------------------
// hssc_pkg
// Shared types, codes and step tables of the six-step Hall commutator.
// ----------------------------------------------------------------------------
package hssc_pkg;

    localparam int CMD_W    = 3;
    localparam int HALL_W   = 3;
    localparam int PULSE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int STEP_W   = 3;
    localparam int EN_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PULSE_W-1:0] BLINK_PERIOD_RST = 16'd500;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HALL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMMUT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BREAK   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SET_RUN = 3'd6;

    // motor status codes
    localparam logic [STATUS_W-1:0] ST_STOP        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STARTUP     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RUN         = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERCURRENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HALL_FAULT  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = 2'd2;

    // enable bits: bit0 U+, bit1 U-, bit2 V+, bit3 V-, bit4 W+, bit5 W-
    localparam logic [EN_W-1:0] EN_UH = 6'h01;
    localparam logic [EN_W-1:0] EN_UL = 6'h02;
    localparam logic [EN_W-1:0] EN_VH = 6'h04;
    localparam logic [EN_W-1:0] EN_VL = 6'h08;
    localparam logic [EN_W-1:0] EN_WH = 6'h10;
    localparam logic [EN_W-1:0] EN_WL = 6'h20;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [HALL_W-1:0]  hall;
        logic [PULSE_W-1:0] pulse;
    } item_t;

    typedef struct packed {
        logic tick;
        logic arm;
    } alarm_ctrl_t;

    // Hall code to commutation step, zero for an invalid code
    function automatic logic [STEP_W-1:0] hall_to_step(input logic [HALL_W-1:0] h);
        logic [STEP_W-1:0] s;
        case (h)
            3'b001:  s = 3'd1;
            3'b011:  s = 3'd2;
            3'b010:  s = 3'd3;
            3'b110:  s = 3'd4;
            3'b100:  s = 3'd5;
            3'b101:  s = 3'd6;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // following step in the chosen rotation direction
    function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] s,
                                                    input logic dir);
        logic [STEP_W-1:0] n;
        if (!dir)
            n = (s == 3'd6) ? 3'd1 : s + 3'd1;
        else
            n = (s == 3'd1) ? 3'd6 : s - 3'd1;
        return n;
    endfunction

    function automatic logic [EN_W-1:0] step_enables(input logic [STEP_W-1:0] s);
        logic [EN_W-1:0] e;
        case (s)
            3'd1:    e = EN_UH | EN_VH | EN_VL;
            3'd2:    e = EN_UH | EN_WH | EN_WL;
            3'd3:    e = EN_VH | EN_WH | EN_WL;
            3'd4:    e = EN_UH | EN_UL | EN_VH;
            3'd5:    e = EN_UH | EN_UL | EN_WH;
            3'd6:    e = EN_VH | EN_VL | EN_WH;
            default: e = '0;
        endcase
        return e;
    endfunction

    // channel that receives the pulse when a step is loaded
    function automatic logic [1:0] step_drive_ch(input logic [STEP_W-1:0] s);
        logic [1:0] c;
        case (s)
            3'd1, 3'd2: c = 2'd0;
            3'd3, 3'd4: c = 2'd1;
            default:    c = 2'd2;
        endcase
        return c;
    endfunction

    // channel that is cleared when a step is loaded
    function automatic logic [1:0] step_clear_ch(input logic [STEP_W-1:0] s);
        logic [1:0] c;
        case (s)
            3'd1:       c = 2'd1;
            3'd2, 3'd3: c = 2'd2;
            3'd4, 3'd5: c = 2'd0;
            default:    c = 2'd1;
        endcase
        return c;
    endfunction

    // high-side channel of the current step
    function automatic logic [1:0] step_high_ch(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] t;
        t = s - 3'd1;
        return t[2:1];
    endfunction

endpackage

>>> hdl/hssc_in_stage.sv
// ----------------------------------------------------------------------------
// hssc_in_stage
// Input register: holds one command item until the engine takes it.
// ----------------------------------------------------------------------------
module hssc_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hssc_pkg::CMD_W-1:0]    cmd,
    input  logic [hssc_pkg::HALL_W-1:0]   hall,
    input  logic [hssc_pkg::PULSE_W-1:0]  pulse,
    input  logic                          take,
    output logic                          item_valid,
    output hssc_pkg::item_t               item
);
    import hssc_pkg::*;

    logic  item_valid_reg;
    item_t item_reg;

    // free when empty or when the held item leaves this cycle
    assign in_ready   = !item_valid_reg || take;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    // hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    // capture the payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd   <= cmd;
            item_reg.hall  <= hall;
            item_reg.pulse <= pulse;
        end
    end

endmodule

>>> hdl/hssc_alarm.sv
// ----------------------------------------------------------------------------
// hssc_alarm
// Overcurrent alarm blink counter: counts ticks once armed and flags a
// LED toggle every blink period.
// ----------------------------------------------------------------------------
module hssc_alarm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hssc_pkg::alarm_ctrl_t         ctrl,
    input  logic [hssc_pkg::PULSE_W-1:0]  blink_period,
    output logic                          toggle
);
    import hssc_pkg::*;

    logic               alarm_on_reg, alarm_on_next;
    logic [PULSE_W-1:0] ticks_reg, ticks_next;
    logic [PULSE_W-1:0] ticks_inc;

    // saturating tick count
    assign ticks_inc = (ticks_reg == {PULSE_W{1'b1}}) ? ticks_reg
                                                      : ticks_reg + PULSE_W'(1);

    always_comb
    begin
        alarm_on_next = alarm_on_reg;
        ticks_next    = ticks_reg;
        toggle        = 1'b0;
        if (ctrl.arm)
        begin
            alarm_on_next = 1'b1;
            ticks_next    = '0;
        end
        else if (ctrl.tick && alarm_on_reg)
        begin
            if (ticks_inc >= blink_period)
            begin
                ticks_next = '0;
                toggle     = 1'b1;
            end
            else
                ticks_next = ticks_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_on_reg <= 1'b0;
            ticks_reg    <= '0;
        end
        else
        begin
            alarm_on_reg <= alarm_on_next;
            ticks_reg    <= ticks_next;
        end
    end

endmodule

>>> hdl/hssc_engine.sv
// ----------------------------------------------------------------------------
// hssc_engine
// Command engine: applies one item to the motor state in a single pass. The
// state registers double as the result register and are shown while
// out_valid is high.
// ----------------------------------------------------------------------------
module hssc_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  hssc_pkg::item_t               item,
    input  logic                          direction,
    input  logic [hssc_pkg::PULSE_W-1:0]  startup_pulse,
    input  logic                          alarm_toggle,
    output hssc_pkg::alarm_ctrl_t         alarm_ctrl,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          u_high_en,
    output logic                          u_low_en,
    output logic                          v_high_en,
    output logic                          v_low_en,
    output logic                          w_high_en,
    output logic                          w_low_en,
    output logic [hssc_pkg::PULSE_W-1:0]  duty_u,
    output logic [hssc_pkg::PULSE_W-1:0]  duty_v,
    output logic [hssc_pkg::PULSE_W-1:0]  duty_w,
    output logic                          driver_enable,
    output logic                          status_led,
    output logic [hssc_pkg::STATUS_W-1:0] status
);
    import hssc_pkg::*;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PULSE_W-1:0]  pv_reg, pv_next;
    logic [PULSE_W-1:0]  run_reg, run_next;
    logic [PULSE_W-1:0]  duty_reg [3];
    logic [PULSE_W-1:0]  duty_next [3];
    logic [EN_W-1:0]     shadow_reg, shadow_next;
    logic [EN_W-1:0]     active_reg, active_next;
    logic                main_reg, main_next;
    logic                drv_reg, drv_next;
    logic                led_reg, led_next;

    logic [STEP_W-1:0]   dec_step;
    logic                dec_ok;
    logic                load_en;
    logic [STEP_W-1:0]   load_step;
    logic [PULSE_W-1:0]  load_pv;
    logic                set_en;
    logic [PULSE_W-1:0]  set_val;
    logic [EN_W-1:0]     en_out;

    assign free      = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    assign dec_step = hall_to_step(item.hall);
    assign dec_ok   = (dec_step != '0);

    assign alarm_ctrl.tick = take && (item.cmd == CMD_TICK);
    assign alarm_ctrl.arm  = take && (item.cmd == CMD_BREAK) && main_reg;

    // decode the command into the next state
    always_comb
    begin
        status_next = status_reg;
        step_next   = step_reg;
        pv_next     = pv_reg;
        run_next    = run_reg;
        shadow_next = shadow_reg;
        active_next = active_reg;
        main_next   = main_reg;
        drv_next    = drv_reg;
        led_next    = led_reg;
        load_en     = 1'b0;
        load_step   = '0;
        load_pv     = pv_reg;
        set_en      = 1'b0;
        set_val     = '0;

        if (take)
        begin
            case (item.cmd)
                CMD_TICK:
                begin
                    if (alarm_toggle)
                        led_next = !led_reg;
                end
                CMD_START:
                begin
                    if (status_reg == ST_STOP)
                    begin
                        if (!dec_ok)
                        begin
                            main_next   = 1'b0;
                            drv_next    = 1'b0;
                            led_next    = 1'b0;
                            status_next = ST_HALL_FAULT;
                        end
                        else
                        begin
                            led_next    = 1'b1;
                            status_next = ST_STARTUP;
                            step_next   = dec_step;
                            drv_next    = 1'b1;
                            pv_next     = startup_pulse;
                            main_next   = 1'b1;
                            load_en     = 1'b1;
                            load_step   = next_step(dec_step, direction);
                            load_pv     = startup_pulse;
                            active_next = step_enables(load_step);
                        end
                    end
                end
                CMD_STOP:
                begin
                    main_next   = 1'b0;
                    drv_next    = 1'b0;
                    led_next    = 1'b0;
                    status_next = ST_STOP;
                    set_en      = 1'b1;
                end
                CMD_HALL:
                begin
                    if (main_reg)
                    begin
                        pv_next = run_reg;
                        if (dec_ok)
                        begin
                            status_next = ST_RUN;
                            step_next   = dec_step;
                        end
                        else
                        begin
                            main_next   = 1'b0;
                            drv_next    = 1'b0;
                            led_next    = 1'b0;
                            status_next = ST_HALL_FAULT;
                        end
                    end
                end
                CMD_COMMUT:
                begin
                    if (main_reg)
                    begin
                        active_next = shadow_reg;
                        if (step_reg inside {[3'd1:3'd6]})
                        begin
                            load_en   = 1'b1;
                            load_step = next_step(step_reg, direction);
                        end
                    end
                end
                CMD_BREAK:
                begin
                    if (main_reg)
                    begin
                        main_next   = 1'b0;
                        drv_next    = 1'b0;
                        led_next    = 1'b1;
                        status_next = ST_OVERCURRENT;
                        set_en      = 1'b1;
                    end
                end
                CMD_SET_RUN:
                begin
                    run_next = item.pulse;
                    if (status_reg == ST_RUN)
                    begin
                        set_en  = 1'b1;
                        set_val = item.pulse;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // preload the shadow enables of the loaded step
        if (load_en)
            shadow_next = step_enables(load_step);
    end

    // compare values: step load or a direct write of the high-side channel
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            duty_next[i] = duty_reg[i];
            if (load_en)
            begin
                if (step_drive_ch(load_step) == 2'(i))
                    duty_next[i] = load_pv;
                else if (step_clear_ch(load_step) == 2'(i))
                    duty_next[i] = '0;
            end
            if (set_en && (step_reg inside {[3'd1:3'd6]})
                && (step_high_ch(step_reg) == 2'(i)))
                duty_next[i] = set_val;
        end
    end

    // advance the state and the result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_STOP;
            step_reg      <= '0;
            pv_reg        <= '0;
            run_reg       <= '0;
            shadow_reg    <= '0;
            active_reg    <= '0;
            main_reg      <= 1'b0;
            drv_reg       <= 1'b0;
            led_reg       <= 1'b0;
            for (int i = 0; i < 3; i++)
                duty_reg[i] <= '0;
        end
        else
        begin
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            status_reg <= status_next;
            step_reg   <= step_next;
            pv_reg     <= pv_next;
            run_reg    <= run_next;
            shadow_reg <= shadow_next;
            active_reg <= active_next;
            main_reg   <= main_next;
            drv_reg    <= drv_next;
            led_reg    <= led_next;
            for (int i = 0; i < 3; i++)
                duty_reg[i] <= duty_next[i];
        end
    end

    // gate the enables by the main output
    assign en_out        = main_reg ? active_reg : '0;
    assign u_high_en     = en_out[0];
    assign u_low_en      = en_out[1];
    assign v_high_en     = en_out[2];
    assign v_low_en      = en_out[3];
    assign w_high_en     = en_out[4];
    assign w_low_en      = en_out[5];
    assign duty_u        = duty_reg[0];
    assign duty_v        = duty_reg[1];
    assign duty_w        = duty_reg[2];
    assign driver_enable = drv_reg;
    assign status_led    = led_reg;
    assign status        = status_reg;

endmodule

>>> hdl/hall_six_step_commutator_core.sv
// An item passes the input register, then the engine's state registers.
// Throughput: one item per cycle; a result held by out_ready low stalls the engine.
// The engine's state registers serve as the result register.
// Reset (rst_n, asynchronous, active low) clears all state, sets blink period to 500.
// ----------------------------------------------------------------------------
// hall_six_step_commutator_core
// Six-step Hall-sensor BLDC commutation controller: input register, command
// engine with alarm blink counter, and configuration registers.
// ----------------------------------------------------------------------------
module hall_six_step_commutator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hssc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hssc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hssc_pkg::CMD_W-1:0]      cmd,
    input  logic [hssc_pkg::HALL_W-1:0]     hall,
    input  logic [hssc_pkg::PULSE_W-1:0]    pulse,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            u_high_en,
    output logic                            u_low_en,
    output logic                            v_high_en,
    output logic                            v_low_en,
    output logic                            w_high_en,
    output logic                            w_low_en,
    output logic [hssc_pkg::PULSE_W-1:0]    duty_u,
    output logic [hssc_pkg::PULSE_W-1:0]    duty_v,
    output logic [hssc_pkg::PULSE_W-1:0]    duty_w,
    output logic                            driver_enable,
    output logic                            status_led,
    output logic [hssc_pkg::STATUS_W-1:0]   status
);
    import hssc_pkg::*;

    logic               direction_reg;
    logic [PULSE_W-1:0] startup_pulse_reg;
    logic [PULSE_W-1:0] blink_period_reg;

    logic        item_valid;
    item_t       item;
    logic        engine_free;
    logic        take;
    alarm_ctrl_t alarm_ctrl;
    logic        alarm_toggle;

    assign take = item_valid && engine_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg     <= 1'b0;
            startup_pulse_reg <= '0;
            blink_period_reg  <= BLINK_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIRECTION:     direction_reg     <= cfg_data[0];
                CFG_STARTUP_PULSE: startup_pulse_reg <= cfg_data;
                CFG_BLINK_PERIOD:  blink_period_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    hssc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .hall       (hall),
        .pulse      (pulse),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    hssc_alarm u_alarm (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (alarm_ctrl),
        .blink_period (blink_period_reg),
        .toggle       (alarm_toggle)
    );

    hssc_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .item          (item),
        .direction     (direction_reg),
        .startup_pulse (startup_pulse_reg),
        .alarm_toggle  (alarm_toggle),
        .alarm_ctrl    (alarm_ctrl),
        .free          (engine_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .u_high_en     (u_high_en),
        .u_low_en      (u_low_en),
        .v_high_en     (v_high_en),
        .v_low_en      (v_low_en),
        .w_high_en     (w_high_en),
        .w_low_en      (w_low_en),
        .duty_u        (duty_u),
        .duty_v        (duty_v),
        .duty_w        (duty_w),
        .driver_enable (driver_enable),
        .status_led    (status_led),
        .status        (status)
    );

endmodule
